/* src/bvc_pkg.sv */
`timescale 1ns / 1ps

package bvc_pkg;

  // item kinds
  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;

  // configuration register indexes
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 7;

  localparam logic [CfgIndexW-1:0] CfgFineX   = 3'd0;
  localparam logic [CfgIndexW-1:0] CfgFineY   = 3'd1;
  localparam logic [CfgIndexW-1:0] CfgFineZ   = 3'd2;
  localparam logic [CfgIndexW-1:0] CfgCoarseX = 3'd3;
  localparam logic [CfgIndexW-1:0] CfgCoarseY = 3'd4;
  localparam logic [CfgIndexW-1:0] CfgCoarseZ = 3'd5;

  localparam logic [CfgDataW-1:0] FineSizeReset   = 7'd64;
  localparam logic [CfgDataW-1:0] CoarseSizeReset = 7'd33;

  // one memory word holds a 2x2x2 fine block, bit index {z,y,x} offset
  localparam int unsigned BlockBits = 8;

  typedef struct packed {
    logic       kind;
    logic [5:0] pos_x;
    logic [5:0] pos_y;
    logic [5:0] pos_z;
    logic       voxel;
  } in_word_t;

  typedef struct packed {
    logic coarse_bit;
    logic out_of_range;
  } out_word_t;

  typedef struct packed {
    logic       we;
    logic       re;
    logic [2:0] sel;
    logic       wbit;
  } mem_ctrl_t;

endpackage

/* src/bvc_mem.sv */
`timescale 1ns / 1ps

module bvc_mem #(
  parameter int unsigned Depth = 35937,
  parameter int unsigned AddrW = 16
) (
  input  logic                              clk_i,
  input  bvc_pkg::mem_ctrl_t                ctrl_i,
  input  logic [AddrW-1:0]                  addr_i,
  output logic [bvc_pkg::BlockBits-1:0]     rdata_o
);

  logic [bvc_pkg::BlockBits-1:0] mem [Depth];

  // single bit write into a block word, whole word read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem[addr_i][ctrl_i.sel] <= ctrl_i.wbit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.re) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

/* src/binary_volume_coarsen_2x_unit.sv */
`timescale 1ns / 1ps
// throughput: one word per cycle, writes and queries alike; busy_o never rises
// a query result is strobed once the word has passed the stage 1 register and the
//   registered read of the block memory
// writes give no result; the receiver cannot stall, results leave unheld
// reset clears pipeline valids and restores the size registers; the fine
//   grid memory is not cleared and must be written before it is queried
module binary_volume_coarsen_2x_unit #(
  parameter int unsigned MAX_X = 64,
  parameter int unsigned MAX_Y = 64,
  parameter int unsigned MAX_Z = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  bvc_pkg::in_word_t                 item_i,
  output logic                              result_valid_o,
  output bvc_pkg::out_word_t                result_o,
  input  logic                              cfg_we_i,
  input  logic [bvc_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [bvc_pkg::CfgDataW-1:0]      cfg_data_i
);

  // block words per axis: block index is (x + 1) >> 1
  localparam int unsigned BlkX  = MAX_X / 2 + 1;
  localparam int unsigned BlkY  = MAX_Y / 2 + 1;
  localparam int unsigned BlkZ  = MAX_Z / 2 + 1;
  localparam int unsigned Depth = BlkX * BlkY * BlkZ;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned MaxXY = (MAX_X > MAX_Y) ? MAX_X : MAX_Y;
  localparam int unsigned MaxAll = (MaxXY > MAX_Z) ? MaxXY : MAX_Z;
  localparam int unsigned SizeTop = (MaxAll > 127) ? MaxAll : 127;
  localparam int unsigned SizeW = $clog2(SizeTop + 1) + 1;

  logic [bvc_pkg::CfgDataW-1:0] fine_x_q, fine_y_q, fine_z_q;
  logic [bvc_pkg::CfgDataW-1:0] coarse_x_q, coarse_y_q, coarse_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fine_x_q   <= bvc_pkg::FineSizeReset;
      fine_y_q   <= bvc_pkg::FineSizeReset;
      fine_z_q   <= bvc_pkg::FineSizeReset;
      coarse_x_q <= bvc_pkg::CoarseSizeReset;
      coarse_y_q <= bvc_pkg::CoarseSizeReset;
      coarse_z_q <= bvc_pkg::CoarseSizeReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bvc_pkg::CfgFineX:   fine_x_q   <= cfg_data_i;
        bvc_pkg::CfgFineY:   fine_y_q   <= cfg_data_i;
        bvc_pkg::CfgFineZ:   fine_z_q   <= cfg_data_i;
        bvc_pkg::CfgCoarseX: coarse_x_q <= cfg_data_i;
        bvc_pkg::CfgCoarseY: coarse_y_q <= cfg_data_i;
        bvc_pkg::CfgCoarseZ: coarse_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // stage 1: accepted word
  logic              s1_valid_q;
  bvc_pkg::in_word_t s1_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      s1_item_q <= item_i;
    end
  end

  // effective fine sizes
  logic [SizeW-1:0] eff_x, eff_y, eff_z;
  assign eff_x = (SizeW'(fine_x_q) < SizeW'(MAX_X)) ? SizeW'(fine_x_q) : SizeW'(MAX_X);
  assign eff_y = (SizeW'(fine_y_q) < SizeW'(MAX_Y)) ? SizeW'(fine_y_q) : SizeW'(MAX_Y);
  assign eff_z = (SizeW'(fine_z_q) < SizeW'(MAX_Z)) ? SizeW'(fine_z_q) : SizeW'(MAX_Z);

  logic             is_query;
  logic             write_ok;
  logic             oor, border, base_ok;
  logic             nb_x, nb_y, nb_z;
  logic [6:0]       base_x, base_y, base_z;
  logic [5:0]       blk_x, blk_y, blk_z;
  logic [AddrW-1:0] addr;
  logic [bvc_pkg::BlockBits-1:0] incl_mask;
  bvc_pkg::mem_ctrl_t mem_ctrl;

  always_comb begin
    is_query = s1_item_q.kind == bvc_pkg::KindQuery;

    write_ok = (SizeW'(s1_item_q.pos_x) < eff_x) && (SizeW'(s1_item_q.pos_y) < eff_y)
            && (SizeW'(s1_item_q.pos_z) < eff_z);

    oor = ({1'b0, s1_item_q.pos_x} >= coarse_x_q) || ({1'b0, s1_item_q.pos_y} >= coarse_y_q)
       || ({1'b0, s1_item_q.pos_z} >= coarse_z_q);
    border = (s1_item_q.pos_x == 6'd0) || (({1'b0, s1_item_q.pos_x} + 7'd1) >= coarse_x_q)
          || (s1_item_q.pos_y == 6'd0) || (({1'b0, s1_item_q.pos_y} + 7'd1) >= coarse_y_q)
          || (s1_item_q.pos_z == 6'd0) || (({1'b0, s1_item_q.pos_z} + 7'd1) >= coarse_z_q);

    // base corner 2c-1, only meaningful when not on the border
    base_x = {s1_item_q.pos_x, 1'b0} - 7'd1;
    base_y = {s1_item_q.pos_y, 1'b0} - 7'd1;
    base_z = {s1_item_q.pos_z, 1'b0} - 7'd1;
    base_ok = (SizeW'(base_x) < eff_x) && (SizeW'(base_y) < eff_y)
           && (SizeW'(base_z) < eff_z);
    nb_x = (SizeW'(base_x) + SizeW'(2)) < eff_x;
    nb_y = (SizeW'(base_y) + SizeW'(2)) < eff_y;
    nb_z = (SizeW'(base_z) + SizeW'(2)) < eff_z;

    for (int k = 0; k < 8; k++) begin
      incl_mask[k] = (!k[0] || nb_x) && (!k[1] || nb_y) && (!k[2] || nb_z);
    end

    // odd base sits at offset 0 of block c, its even neighbour at offset 1
    if (is_query) begin
      blk_x = s1_item_q.pos_x;
      blk_y = s1_item_q.pos_y;
      blk_z = s1_item_q.pos_z;
    end else begin
      blk_x = 6'(({1'b0, s1_item_q.pos_x} + 7'd1) >> 1);
      blk_y = 6'(({1'b0, s1_item_q.pos_y} + 7'd1) >> 1);
      blk_z = 6'(({1'b0, s1_item_q.pos_z} + 7'd1) >> 1);
    end
    addr = AddrW'(blk_x) + AddrW'(BlkX) * (AddrW'(blk_y) + AddrW'(BlkY) * AddrW'(blk_z));

    mem_ctrl.we   = s1_valid_q && !is_query && write_ok;
    mem_ctrl.re   = s1_valid_q && is_query && !oor && !border && base_ok;
    mem_ctrl.sel  = {~s1_item_q.pos_z[0], ~s1_item_q.pos_y[0], ~s1_item_q.pos_x[0]};
    mem_ctrl.wbit = s1_item_q.voxel;
  end

  logic [bvc_pkg::BlockBits-1:0] rdata;

  bvc_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctrl_i  (mem_ctrl),
    .addr_i  (addr),
    .rdata_o (rdata)
  );

  // stage 2: read data arrives
  logic                          s2_valid_q;
  logic                          s2_oor_q;
  logic                          s2_zero_q;
  logic [bvc_pkg::BlockBits-1:0] s2_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q && is_query;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && is_query) begin
      s2_oor_q  <= oor;
      s2_zero_q <= oor || border || !base_ok;
      s2_mask_q <= incl_mask;
    end
  end

  assign result_valid_o          = s2_valid_q;
  assign result_o.out_of_range   = s2_oor_q;
  assign result_o.coarse_bit     = !s2_zero_q && (&(rdata | ~s2_mask_q));

endmodule

/* src/bvc_checker.sv */
`timescale 1ns / 1ps

module bvc_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  bvc_pkg::in_word_t             item_i,
  input  logic                          result_valid_i,
  input  bvc_pkg::out_word_t            result_i
);

  logic query_acc;
  assign query_acc = start_i && !busy_i && (item_i.kind == bvc_pkg::KindQuery);

  // every accepted query gets its result word
  a_query_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_acc |-> ##2 result_valid_i)
    else $error("query accepted without a result two cycles later");

  // no result without a query behind it
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |-> $past(query_acc, 2))
    else $error("result strobed with no query two cycles earlier");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_i && result_i.out_of_range) |-> !result_i.coarse_bit)
    else $error("out of range result carries a set coarse bit");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> !busy_i)
    else $error("busy raised after start");

endmodule

bind binary_volume_coarsen_2x_unit bvc_checker u_bvc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_i         (busy_o),
  .item_i         (item_i),
  .result_valid_i (result_valid_o),
  .result_i       (result_o)
);
